>>> rtl/crc32rs_pkg.sv
// Package: shared constants, register indexes and the CRC-32 bit-step function.
package crc32rs_pkg;

  localparam int unsigned CrcW  = 32;
  localparam int unsigned WordW = 16;
  localparam int unsigned ByteW = 8;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CrcW-1:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [CrcW-1:0] CRC_ONES = 32'hFFFF_FFFF;

  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  // Register indexes on the configuration port
  localparam cfg_idx_t REG_SEED       = 2'd0;
  localparam cfg_idx_t REG_WIDTH_MODE = 2'd1;

  // Width selection codes
  typedef enum logic {
    MODE_BYTE = 1'b0,
    MODE_WORD = 1'b1
  } width_mode_t;

  // One LSB-first shift of the reflected CRC register
  function automatic logic [CrcW-1:0] crc_shift1(input logic [CrcW-1:0] crc);
    logic [CrcW-1:0] sh;
    sh = {1'b0, crc[CrcW-1:1]};
    return crc[0] ? (sh ^ CRC_POLY) : sh;
  endfunction

endpackage

>>> rtl/crc32rs_absorb.sv
// Combinational absorber: folds one data word (8 or 16 bits) into the CRC.
module crc32rs_absorb
  import crc32rs_pkg::*;
(
  input  logic [CrcW-1:0]  crc_in,
  input  logic [WordW-1:0] data_word,
  input  width_mode_t      mode,
  output logic [CrcW-1:0]  crc_out
);

  logic [CrcW-1:0] lo_crc;
  logic [CrcW-1:0] hi_crc;

  // Low byte: always eight steps
  always_comb begin
    lo_crc = crc_in ^ {{(CrcW-ByteW){1'b0}}, data_word[ByteW-1:0]};
    for (int i = 0; i < ByteW; i++) begin
      lo_crc = crc_shift1(lo_crc);
    end
  end

  // High byte: eight more steps in word mode
  always_comb begin
    hi_crc = lo_crc ^ {{(CrcW-ByteW){1'b0}}, data_word[WordW-1:ByteW]};
    for (int i = 0; i < ByteW; i++) begin
      hi_crc = crc_shift1(hi_crc);
    end
  end

  assign crc_out = (mode == MODE_WORD) ? hi_crc : lo_crc;

endmodule

>>> rtl/crc32_reflected_stream_top.sv
// Top level: reflected CRC-32 stream engine over 16-bit words.
//
//  Channel  Direction  Handshake               Payload
//  in_      input      in_valid / in_stall     in_data_word, in_first_word, in_last_word
//  out_     output     out_valid / out_stall   out_crc_value
//  cfg_     input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One item per cycle sustained while in_stall is low. An accepted item lands
// in the input register and is then folded into the running CRC; a last
// item puts its result in the output register at the same time.
// The running CRC sits in one register fed by 16 unrolled bit steps.
// Reset (rst_n low, synchronous) empties both registers, sets the running CRC
// to all ones, seed to zero and word mode. A stalled result holds; a last
// item that reaches the input register then waits there and in_stall rises,
// while non-last items ahead of it keep flowing. cfg_ready is always high.
module crc32_reflected_stream_top
  import crc32rs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // input items
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [WordW-1:0] in_data_word,
  input  logic             in_first_word,
  input  logic             in_last_word,
  // results
  output logic             out_valid,
  input  logic             out_stall,
  output logic [CrcW-1:0]  out_crc_value,
  // configuration writes
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  cfg_idx_t         cfg_index,
  input  logic [CrcW-1:0]  cfg_data
);

  // Configuration registers
  logic [CrcW-1:0] seed_r;
  width_mode_t     mode_r;

  // Input register
  logic             in_vld_r;
  logic [WordW-1:0] in_word_r;
  logic             in_first_r;
  logic             in_last_r;

  // Running CRC and result register
  logic [CrcW-1:0] crc_r;
  logic [CrcW-1:0] crc_nxt;
  logic [CrcW-1:0] crc_base;
  logic            out_vld_r;
  logic [CrcW-1:0] out_crc_r;

  logic adv;
  logic in_acc;
  logic out_free;

  assign cfg_ready = 1'b1;

  // Output register can take a new result when empty or being drained
  assign out_free = !out_vld_r || !out_stall;
  // Held item moves on unless it is a last item blocked by a full output
  assign adv      = in_vld_r && (!in_last_r || out_free);
  assign in_stall = in_vld_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
      mode_r <= MODE_WORD;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SEED:       seed_r <= cfg_data;
        REG_WIDTH_MODE: mode_r <= width_mode_t'(cfg_data[0]);
        default:        ;
      endcase
    end
  end

  // Capture the item; drop the valid once it has advanced
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_acc) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_word_r  <= in_data_word;
      in_first_r <= in_first_word;
      in_last_r  <= in_last_word;
    end
  end

  // First word restarts from the inverted seed
  assign crc_base = in_first_r ? ~seed_r : crc_r;

  crc32rs_absorb u_absorb (
    .crc_in    (crc_base),
    .data_word (in_word_r),
    .mode      (mode_r),
    .crc_out   (crc_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= CRC_ONES;
    end else if (adv) begin
      crc_r <= crc_nxt;
    end
  end

  // Result register: load on an advancing last item, clear when drained
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv && in_last_r) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_last_r) begin
      out_crc_r <= ~crc_nxt;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_crc_value = out_crc_r;

endmodule
